/* rtl/core/tea_pkg.sv */
package tea_pkg;

    localparam int unsigned TEA_ROUNDS = 32;
    localparam int unsigned TEA_HALVES = 2 * TEA_ROUNDS;
    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
    localparam logic [31:0] TEA_DEC_START = 32'hC6EF_3720;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    typedef struct packed {
        logic        valid;
        t_cmd        cmd;
        logic [31:0] a;
        logic [31:0] b;
    } t_blk;

    function automatic logic [31:0] tea_round_const(input int unsigned k);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(k);
        return prod[31:0];
    endfunction

endpackage

/* rtl/core/tea_cfg_regs.sv */
module tea_cfg_regs
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_key        o_key
);

    t_key     r_key;
    t_key     n_key;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        if (w_wr) begin
            case (w_idx)
                REG_KEY0: n_key.k0 = pwdata;
                REG_KEY1: n_key.k1 = pwdata;
                REG_KEY2: n_key.k2 = pwdata;
                REG_KEY3: n_key.k3 = pwdata;
                default:  n_key = r_key;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY0: prdata = r_key.k0;
            REG_KEY1: prdata = r_key.k1;
            REG_KEY2: prdata = r_key.k2;
            REG_KEY3: prdata = r_key.k3;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

`ifndef SYNTHESIS
    a_write_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && pready) |=> ((paddr != $past(paddr)) || (prdata == $past(pwdata))))
        else $error("key register does not read back the written value");
`endif

endmodule

/* rtl/core/tea_half_round.sv */
module tea_half_round
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_key        i_key,
    input  logic [31:0] i_rc_enc,
    input  logic [31:0] i_rc_dec,
    input  logic        i_second,
    input  t_blk        i_blk,
    output t_blk        o_blk
);

    t_blk        r_blk;
    t_blk        n_blk;
    logic        w_dec;
    logic        w_to_b;
    logic [31:0] w_src;
    logic [31:0] w_rc;
    logic [31:0] w_ka;
    logic [31:0] w_kb;
    logic [31:0] w_mix;
    logic [31:0] w_dst;
    logic [31:0] w_res;

    // Encryption updates a then b; decryption updates b then a with subtraction.
    assign w_dec  = (i_blk.cmd == CMD_DECRYPT);
    assign w_to_b = w_dec ^ i_second;
    assign w_src  = w_to_b ? i_blk.a : i_blk.b;
    assign w_dst  = w_to_b ? i_blk.b : i_blk.a;
    assign w_ka   = w_to_b ? i_key.k2 : i_key.k0;
    assign w_kb   = w_to_b ? i_key.k3 : i_key.k1;
    assign w_rc   = w_dec ? i_rc_dec : i_rc_enc;
    assign w_mix  = ({w_src[27:0], 4'b0000} + w_ka) ^ (w_src + w_rc)
                  ^ ({5'b00000, w_src[31:5]} + w_kb);
    assign w_res  = w_dec ? (w_dst - w_mix) : (w_dst + w_mix);

    always_comb begin
        n_blk = i_blk;
        if (w_to_b) begin
            n_blk.b = w_res;
        end else begin
            n_blk.a = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk.valid <= 1'b0;
        end else begin
            r_blk.valid <= i_blk.valid;
        end
        r_blk.cmd <= n_blk.cmd;
        r_blk.a   <= n_blk.a;
        r_blk.b   <= n_blk.b;
    end

    assign o_blk = r_blk;

`ifndef SYNTHESIS
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_blk.valid |=> o_blk.valid)
        else $error("request lost in a cipher stage");
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_blk.valid |=> !o_blk.valid)
        else $error("request invented in a cipher stage");
    a_cmd_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_blk.valid |=> (o_blk.cmd == $past(i_blk.cmd)))
        else $error("command changed inside the pipeline");
    a_other_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_blk.valid |=> ($past(w_to_b) ? (o_blk.a == $past(i_blk.a))
                                        : (o_blk.b == $past(i_blk.b))))
        else $error("half-round touched the word it must pass through");
`endif

endmodule

/* rtl/core/tea_block_cipher_core.sv */
// TEA block cipher core, 64-bit blocks, 128-bit key, 32 rounds.
// Key: four 32-bit words written over the APB port at byte addresses 0x0,
// 0x4, 0x8 and 0xC; they read back at the same addresses. The user must
// change keys only while no request is in flight; this is not enforced.
// Request: drive i_command (0 encrypt, 1 decrypt), i_word_first and
// i_word_second with start high; the request is taken at that clock edge.
// busy is always low, so a new request may be issued in every cycle.
// Result: o_out_first and o_out_second are valid for exactly one cycle while
// o_out_valid is high. The first stage captures the request at the request
// edge, and the result then passes through the remaining register stages
// to the outputs. Each of the 64 half-rounds is one register stage, so
// throughput is one block per cycle and results leave in request order.
// The receiver cannot stall the core and must take each result when shown.
// Reset (i_rst_n low, synchronous) clears the key to zero and drops every
// request in flight; no result appears until a new request has passed
// through the full pipeline.
module tea_block_cipher_core
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_word_first,
    input  logic [31:0] i_word_second,
    output logic        o_out_valid,
    output logic [31:0] o_out_first,
    output logic [31:0] o_out_second,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_key w_key;
    t_blk w_blk [0:TEA_HALVES];

    assign busy = 1'b0;

    tea_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    assign w_blk[0].valid = start && !busy;
    assign w_blk[0].cmd   = t_cmd'(i_command);
    assign w_blk[0].a     = i_word_first;
    assign w_blk[0].b     = i_word_second;

    for (genvar h = 0; h < TEA_HALVES; h++) begin : g_half
        localparam int unsigned RND = h / 2;

        tea_half_round u_half (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_key    (w_key),
            .i_rc_enc (tea_round_const(RND + 1)),
            .i_rc_dec (TEA_DEC_START - tea_round_const(RND)),
            .i_second (1'((h % 2) != 0)),
            .i_blk    (w_blk[h]),
            .o_blk    (w_blk[h+1])
        );
    end

    assign o_out_valid  = w_blk[TEA_HALVES].valid;
    assign o_out_first  = w_blk[TEA_HALVES].a;
    assign o_out_second = w_blk[TEA_HALVES].b;

endmodule
